[hw/rtl/sac_pkg.sv]
// shared types, constants and codes for the set-associative cache
`timescale 1ns / 1ps
package sac_pkg;

  localparam int ADDR_BITS        = 16;
  localparam int MAX_WAYS         = 8;
  localparam int MAX_SETS         = 256;
  localparam int MAX_BLOCK_BYTES  = 64;
  localparam int MAX_ACCESS_BYTES = 8;

  localparam int WAY_W     = $clog2(MAX_WAYS);
  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int TAG_W     = 16;
  localparam int AGE_W     = 3;
  localparam int WORD_W    = ADDR_BITS - 3;
  localparam int LWORD_W   = $clog2(MAX_BLOCK_BYTES / 8);
  localparam int CADDR_W   = SET_W + WAY_W + LWORD_W;
  localparam int MEM_WORDS = 2 ** WORD_W;
  localparam int C_WORDS   = 2 ** CADDR_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  localparam logic [1:0] CFG_WAYS  = 2'd0;
  localparam logic [1:0] CFG_SETS  = 2'd1;
  localparam logic [1:0] CFG_BLOCK = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] address;
    logic [3:0]  num_bytes;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_data;
    logic        bad_access;
  } out_item_t;

  typedef struct packed {
    in_item_t             req;
    logic                 bad;
    logic [SET_W-1:0]     set;
    logic [TAG_W-1:0]     tag;
    logic [LWORD_W-1:0]   lword;
    logic [WORD_W-1:0]    fill_base;
    logic [LWORD_W-1:0]   fill_last;
    logic [3:0]           nways;
  } dec_item_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } way_entry_t;

  typedef way_entry_t [MAX_WAYS-1:0] tag_row_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP,
    BK_ST0,
    BK_ST1,
    BK_FILL_RD,
    BK_FILL_WR,
    BK_RD0,
    BK_RD1,
    BK_RD2
  } back_state_t;

endpackage

[hw/rtl/sac_front.sv]
// front end: configuration registers, request decode and acceptance
`timescale 1ns / 1ps
module sac_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sac_pkg::in_item_t  in_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output sac_pkg::dec_item_t q_data,
  output logic               flush
);
  import sac_pkg::*;

  logic [3:0] cfg_ways_r;
  logic [3:0] cfg_sets_r;
  logic [2:0] cfg_block_r;

  logic [3:0]  sl_eff;
  logic [2:0]  bl_eff;
  logic [3:0]  nw_eff;
  logic [15:0] mask;
  logic [6:0]  off_sum;
  logic [6:0]  blk_sz;
  logic [5:0]  off;
  logic [15:0] set_full;
  logic [4:0]  tsh;
  logic [15:0] base;
  logic [3:0]  words;
  logic [15:0] addr;

  assign cfg_ready = 1'b1;
  assign busy      = clearing | q_full;
  assign q_push    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ways_r  <= 4'd1;
      cfg_sets_r  <= 4'd0;
      cfg_block_r <= 3'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WAYS:  cfg_ways_r  <= cfg_data;
        CFG_SETS:  cfg_sets_r  <= cfg_data;
        CFG_BLOCK: cfg_block_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign flush = cfg_valid & (cfg_index == CFG_WAYS || cfg_index == CFG_SETS ||
                              cfg_index == CFG_BLOCK);

  always_comb begin
    addr     = in_item.address;
    sl_eff   = (cfg_sets_r > 4'd8) ? 4'd8 : cfg_sets_r;
    bl_eff   = (cfg_block_r > 3'd6) ? 3'd6 : cfg_block_r;
    nw_eff   = (cfg_ways_r == 4'd0) ? 4'd1 : ((cfg_ways_r > 4'd8) ? 4'd8 : cfg_ways_r);
    mask     = (16'd1 << bl_eff) - 16'd1;
    blk_sz   = 7'd1 << bl_eff;
    off      = addr[5:0] & mask[5:0];
    off_sum  = {1'b0, off} + {3'b000, in_item.num_bytes};
    set_full = (addr >> bl_eff) & ((16'd1 << sl_eff) - 16'd1);
    tsh      = {2'b00, bl_eff} + {1'b0, sl_eff};
    base     = addr & ~mask;
    words    = (bl_eff > 3'd3) ? (4'd1 << (bl_eff - 3'd3)) : 4'd1;

    q_data.req       = in_item;
    q_data.bad       = (in_item.num_bytes == 4'd0) || (in_item.num_bytes > 4'd8) ||
                       (off_sum > blk_sz);
    q_data.set       = set_full[SET_W-1:0];
    q_data.tag       = addr >> tsh;
    q_data.lword     = off[5:3];
    q_data.fill_base = base[15:3];
    q_data.fill_last = 3'(words - 4'd1);
    q_data.nways     = nw_eff;
  end

endmodule

[hw/rtl/sac_queue.sv]
// two-entry queue of decoded requests between front and back end
`timescale 1ns / 1ps
module sac_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sac_pkg::dec_item_t push_data,
  input  logic               pop,
  output sac_pkg::dec_item_t head,
  output logic               full,
  output logic               empty
);
  import sac_pkg::*;

  dec_item_t  entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head  = entry_r[rd_ptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/sac_back.sv]
// back end: memory clear, tag lookup, lru update, refill, write-through and result
`timescale 1ns / 1ps
module sac_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                flush,
  input  logic                q_empty,
  input  sac_pkg::dec_item_t  q_head,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  output sac_pkg::out_item_t  out_item
);
  import sac_pkg::*;

  back_state_t state_r, state_nxt;
  dec_item_t   cur_r, cur_nxt;
  tag_row_t    row_r, row_nxt;
  logic        hit_r, hit_nxt;
  logic [WAY_W-1:0]   way_r, way_nxt;
  logic [WORD_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [LWORD_W-1:0] fill_k_r, fill_k_nxt;
  logic [63:0]        word0_r, word0_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [MAX_SETS-1:0] set_ok_r;

  // memories
  logic [63:0]        bmem [MEM_WORDS];
  logic [63:0]        cmem [C_WORDS];
  tag_row_t           tmem [MAX_SETS];
  logic [63:0]        bm_q_r, cm_q_r;
  tag_row_t           tm_q_r;

  logic               bm_we, cm_we, tm_we;
  logic [7:0]         bm_be, cm_be;
  logic [WORD_W-1:0]  bm_addr;
  logic [CADDR_W-1:0] cm_addr;
  logic [SET_W-1:0]   tm_addr;
  logic [63:0]        bm_wd, cm_wd;

  // lookup
  tag_row_t           row_eff, row_new;
  logic               lk_hit, lk_found;
  logic [WAY_W-1:0]   lk_hw, lk_vw, lk_w;
  logic [AGE_W-1:0]   lk_best;
  logic [3:0]         lk_ref;

  // byte lanes
  logic [7:0]  st_lane [16];
  logic [15:0] st_be;
  logic [7:0]  rd_win [16];
  logic [63:0] rd_data;
  logic [2:0]  lo;
  logic [3:0]  idx;
  logic [3:0]  dl;
  logic [2:0]  pos;
  logic [SET_W+WAY_W-1:0] line;

  assign q_pop     = (state_r == BK_IDLE) & ~q_empty;
  assign clearing  = (state_r == BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    for (int b = 0; b < 8; b++) begin
      if (bm_we && bm_be[b]) bmem[bm_addr][8*b +: 8] <= bm_wd[8*b +: 8];
    end
    bm_q_r <= bmem[bm_addr];
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 8; b++) begin
      if (cm_we && cm_be[b]) cmem[cm_addr][8*b +: 8] <= cm_wd[8*b +: 8];
    end
    cm_q_r <= cmem[cm_addr];
  end

  always_ff @(posedge clk) begin
    if (tm_we) tmem[tm_addr] <= row_r;
    tm_q_r <= tmem[tm_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_ok_r <= '0;
    end else if (flush) begin
      set_ok_r <= '0;
    end else if (tm_we) begin
      set_ok_r[tm_addr] <= 1'b1;
    end
  end

  // tag row search and lru ranking
  always_comb begin
    row_eff  = set_ok_r[cur_r.set] ? tm_q_r : '0;
    lk_hit   = 1'b0;
    lk_hw    = '0;
    lk_found = 1'b0;
    lk_vw    = '0;
    lk_best  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!lk_hit && (4'(i) < cur_r.nways) && row_eff[i].valid &&
          row_eff[i].tag == cur_r.tag) begin
        lk_hit = 1'b1;
        lk_hw  = WAY_W'(i);
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!lk_found && (4'(i) < cur_r.nways)) begin
        if (!row_eff[i].valid) begin
          lk_vw    = WAY_W'(i);
          lk_found = 1'b1;
        end else if (i == 0 || row_eff[i].age > lk_best) begin
          lk_best = row_eff[i].age;
          lk_vw   = WAY_W'(i);
        end
      end
    end
    lk_w = lk_hit ? lk_hw : lk_vw;
    if (lk_hit)        lk_ref = {1'b0, row_eff[lk_hw].age};
    else if (lk_found) lk_ref = 4'(MAX_WAYS);
    else               lk_ref = {1'b0, row_eff[lk_vw].age};
    row_new = row_eff;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if ((4'(j) < cur_r.nways) && (WAY_W'(j) != lk_w) && row_eff[j].valid &&
          ({1'b0, row_eff[j].age} < lk_ref) && (row_eff[j].age != 3'd7)) begin
        row_new[j].age = row_eff[j].age + 3'd1;
      end
    end
    row_new[lk_w].age = '0;
    if (cur_r.req.cmd == CMD_LOAD) begin
      row_new[lk_w].valid = 1'b1;
      if (!lk_hit) row_new[lk_w].tag = cur_r.tag;
    end
  end

  // store lanes and load extraction over a two-word window
  always_comb begin
    lo = cur_r.req.address[2:0];
    for (int l = 0; l < 16; l++) begin
      dl = 4'(l) - {1'b0, lo};
      pos = 3'(cur_r.req.num_bytes - 4'd1 - dl);
      st_be[l]   = (4'(l) >= {1'b0, lo}) && (dl < cur_r.req.num_bytes);
      st_lane[l] = cur_r.req.write_data[{pos, 3'b000} +: 8];
    end
    for (int l = 0; l < 8; l++) begin
      rd_win[l]     = word0_r[8*l +: 8];
      rd_win[l + 8] = cm_q_r[8*l +: 8];
    end
    rd_data = '0;
    for (int k = 0; k < 8; k++) begin
      idx = {1'b0, lo} + cur_r.req.num_bytes - 4'd1 - 4'(k);
      if (4'(k) < cur_r.req.num_bytes) rd_data[8*k +: 8] = rd_win[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    row_r      <= row_nxt;
    hit_r      <= hit_nxt;
    way_r      <= way_nxt;
    fill_k_r   <= fill_k_nxt;
    word0_r    <= word0_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    row_nxt       = row_r;
    hit_nxt       = hit_r;
    way_nxt       = way_r;
    clr_cnt_nxt   = clr_cnt_r;
    fill_k_nxt    = fill_k_r;
    word0_nxt     = word0_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    line          = {cur_r.set, way_r};
    bm_we   = 1'b0;
    bm_be   = '0;
    bm_addr = cur_r.req.address[15:3];
    bm_wd   = '0;
    cm_we   = 1'b0;
    cm_be   = '0;
    cm_addr = {line, cur_r.lword};
    cm_wd   = '0;
    tm_we   = 1'b0;
    tm_addr = cur_r.set;
    unique case (state_r)
      BK_CLEAR: begin
        bm_we       = 1'b1;
        bm_be       = '1;
        bm_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        tm_addr = q_head.set;
        if (!q_empty) begin
          cur_nxt = q_head;
          if (q_head.bad) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{hit: 1'b0, read_data: '0, bad_access: 1'b1};
          end else begin
            state_nxt = BK_LOOKUP;
          end
        end
      end
      BK_LOOKUP: begin
        row_nxt    = row_new;
        hit_nxt    = lk_hit;
        way_nxt    = lk_w;
        fill_k_nxt = '0;
        if (cur_r.req.cmd == CMD_STORE) state_nxt = BK_ST0;
        else if (lk_hit)                state_nxt = BK_RD0;
        else                            state_nxt = BK_FILL_RD;
      end
      BK_ST0: begin
        bm_we = 1'b1;
        bm_be = st_be[7:0];
        for (int l = 0; l < 8; l++) bm_wd[8*l +: 8] = st_lane[l];
        cm_we = hit_r;
        cm_be = st_be[7:0];
        cm_wd = bm_wd;
        tm_we = hit_r;
        state_nxt = BK_ST1;
      end
      BK_ST1: begin
        bm_addr = cur_r.req.address[15:3] + 1'b1;
        bm_we   = 1'b1;
        bm_be   = st_be[15:8];
        for (int l = 0; l < 8; l++) bm_wd[8*l +: 8] = st_lane[l + 8];
        cm_addr = {line, cur_r.lword + 1'b1};
        cm_we   = hit_r;
        cm_be   = st_be[15:8];
        cm_wd   = bm_wd;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{hit: hit_r, read_data: '0, bad_access: 1'b0};
        state_nxt     = BK_IDLE;
      end
      BK_FILL_RD: begin
        bm_addr   = cur_r.fill_base + WORD_W'(fill_k_r);
        state_nxt = BK_FILL_WR;
      end
      BK_FILL_WR: begin
        cm_addr = {line, fill_k_r};
        cm_we   = 1'b1;
        cm_be   = '1;
        cm_wd   = bm_q_r;
        if (fill_k_r == cur_r.fill_last) begin
          state_nxt = BK_RD0;
        end else begin
          fill_k_nxt = fill_k_r + 1'b1;
          state_nxt  = BK_FILL_RD;
        end
      end
      BK_RD0: begin
        tm_we     = 1'b1;
        state_nxt = BK_RD1;
      end
      BK_RD1: begin
        cm_addr   = {line, cur_r.lword + 1'b1};
        word0_nxt = cm_q_r;
        state_nxt = BK_RD2;
      end
      BK_RD2: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{hit: hit_r, read_data: rd_data, bad_access: 1'b0};
        state_nxt     = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == BK_IDLE || $past(state_r) == BK_ST1 ||
                     $past(state_r) == BK_RD2))
    else $error("result strobe from an unexpected state");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.bad_access |-> !out_item_r.hit && out_item_r.read_data == '0)
    else $error("rejected access carries hit or data");

  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && $past(state_r) == BK_ST1 |-> out_item_r.read_data == '0)
    else $error("store result carries data");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_CLEAR |-> !q_pop)
    else $error("request taken during memory clear");

endmodule

[hw/rtl/set_assoc_cache_lru_write_through.sv]
// top level of the set-associative write-through cache with lru replacement
`timescale 1ns / 1ps
// After reset the block clears its 64 KiB backing memory, one 8-byte word a
// cycle, and holds busy high until the clear is done; configuration writes are
// taken throughout. A request is taken when start is high and busy low; up to
// two requests queue behind the one being served. Each request gives one result
// strobed on out_valid for one cycle. A rejected access is answered from idle;
// a store passes lookup and two write states, a load hit lookup and three read
// states; a load miss first refills the block word by word, at least one word.
module set_assoc_cache_lru_write_through (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sac_pkg::in_item_t  in_item,
  output logic               out_valid,
  output sac_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  import sac_pkg::*;

  logic      clearing;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  logic      flush;
  dec_item_t q_data;
  dec_item_t q_head;

  sac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .flush     (flush)
  );

  sac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  sac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (flush),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
